/* rtl/core/swpp_pkg.sv */
package swpp_pkg;

  // fixed field widths of the stream words and the config register
  localparam int unsigned SampleFieldW = 16;
  localparam int unsigned RangeFieldW  = 16;
  localparam int unsigned CfgW         = 9;

  // input word: one sample and the end of sequence flag
  typedef struct packed {
    logic [SampleFieldW-1:0] sample;
    logic                    last;
  } swpp_in_t;

  // output word: one result per input word
  typedef struct packed {
    logic [RangeFieldW-1:0] window_range;
    logic                   window_full;
    logic [RangeFieldW-1:0] best_range;
    logic                   is_final;
  } swpp_out_t;

  // side info that travels with a word down the result pipeline
  typedef struct packed {
    logic full;
    logic last;
  } swpp_tag_t;

endpackage

/* rtl/core/swpp_cell.sv */
module swpp_cell #(
  parameter int unsigned SW = 16
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic          restart_i,
  input  logic [SW-1:0] sample_i,
  input  logic [SW-1:0] prev_min_i,
  input  logic [SW-1:0] prev_max_i,
  output logic [SW-1:0] min_o,
  output logic [SW-1:0] max_o
);

  logic [SW-1:0] min_q, min_d;
  logic [SW-1:0] max_q, max_d;

  // extremes of the newest samples, one more than the neighbor covers
  always_comb begin
    if (restart_i) begin
      min_d = sample_i;
      max_d = sample_i;
    end else begin
      min_d = (sample_i < prev_min_i) ? sample_i : prev_min_i;
      max_d = (sample_i > prev_max_i) ? sample_i : prev_max_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

/* rtl/core/swpp_range.sv */
module swpp_range #(
  parameter int unsigned SW    = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IW    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  swpp_pkg::swpp_tag_t tag_i,
  input  logic [SW-1:0]      cell_min_i [DEPTH],
  input  logic [SW-1:0]      cell_max_i [DEPTH],
  input  logic [IW-1:0]      sel_i,
  output logic               valid_o,
  output swpp_pkg::swpp_tag_t tag_o,
  output logic [SW-1:0]      range_o
);
  import swpp_pkg::*;

  localparam int unsigned LoW = IW / 2;
  localparam int unsigned HiW = IW - LoW;
  localparam int unsigned NumGroups = 2 ** HiW;

  logic [LoW-1:0] sel_lo;
  logic [HiW-1:0] sel_hi;
  logic [HiW-1:0] sel_hi_q;

  logic [SW-1:0] grp_min_d [NumGroups];
  logic [SW-1:0] grp_max_d [NumGroups];
  logic [SW-1:0] grp_min_q [NumGroups];
  logic [SW-1:0] grp_max_q [NumGroups];
  logic          v1_q, v2_q;
  swpp_tag_t     tag1_q, tag2_q;
  logic [SW-1:0] range_q, range_d;

  assign sel_lo = sel_i[LoW-1:0];
  assign sel_hi = sel_i[IW-1:LoW];

  // first level: pick the same offset inside every group of cells
  always_comb begin
    logic [IW-1:0] idx;
    for (int g = 0; g < NumGroups; g++) begin
      idx = {HiW'(g), sel_lo};
      if (idx < IW'(DEPTH - 1) || idx == IW'(DEPTH - 1)) begin
        grp_min_d[g] = cell_min_i[idx];
        grp_max_d[g] = cell_max_i[idx];
      end else begin
        grp_min_d[g] = '0;
        grp_max_d[g] = '0;
      end
    end
  end

  // group select travels with its word into the second level
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NumGroups; g++) begin
        grp_min_q[g] <= grp_min_d[g];
        grp_max_q[g] <= grp_max_d[g];
      end
      sel_hi_q <= sel_hi;
      tag1_q   <= tag_i;
      tag2_q   <= tag1_q;
      range_q  <= range_d;
    end
  end

  // second level: pick the group, then take the spread
  assign range_d = grp_max_q[sel_hi_q] - grp_min_q[sel_hi_q];

  // word valid through both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign tag_o   = tag2_q;
  assign range_o = range_q;

endmodule

/* rtl/core/sliding_window_peak_to_peak_core.sv */
// sliding window peak-to-peak detector
//
// input channel (in_valid_i / in_stall_o / in_word_i): one sample word per
// cycle unless stalled, with a last flag closing a sequence. output channel
// (out_valid_o / out_stall_i / out_word_o): exactly one result word per input
// word, in order: spread of the window, window full flag, best full-window
// spread of the sequence and the closing flag. config channel (cfg_valid_i /
// cfg_ready_o / cfg_data_i): window length, always ready; the user must write
// it only while no word is in flight, which the block does not enforce;
// 0 acts as 1, values above MAX_WINDOW as MAX_WINDOW. throughput is one word
// per cycle unless stalled. out_valid_o follows the accept edge: the cell
// row loads at that edge, then two mux levels over the cells and the
// best-range compare take one register stage each. each cell keeps the min
// and max of the newest samples, one more than its neighbor, so the window
// extremes are read from the cell at the held count. when the receiver stalls
// a waiting word, the whole pipeline and the input hold. reset clears all
// valids, fill count and best range and sets window length to 1; the cell
// row needs no clearing, it reloads on the first sample of each sequence.
module sliding_window_peak_to_peak_core #(
  parameter int unsigned MAX_WINDOW   = 256,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swpp_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  swpp_pkg::swpp_in_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output swpp_pkg::swpp_out_t              out_word_o
);
  import swpp_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned IW    = (MAX_WINDOW > 4) ? $clog2(MAX_WINDOW) : 2;
  localparam int unsigned LenW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW  = (LenW > CfgW) ? LenW : CfgW;
  localparam int unsigned SelW  = (IW > LenW) ? IW : LenW;

  logic                en;
  logic                accept;
  logic [CfgW-1:0]     len_cfg_q;
  logic [LenW-1:0]     eff_len;
  logic [SelW-1:0]     sel_wide;
  logic [IW-1:0]       sel;
  logic [IW-1:0]       sel0_q;
  logic [LenW-1:0]     fill_q, fill_d;
  logic [LenW:0]       held_inc;
  logic [LenW-1:0]     held;
  logic                restart_q;
  logic [SW+SampleFieldW-1:0] sample_wide;
  logic [SW-1:0]       sample;
  logic                v0_q;
  swpp_tag_t           tag0_q;
  logic [SW-1:0]       cell_min [MAX_WINDOW];
  logic [SW-1:0]       cell_max [MAX_WINDOW];
  logic                v2;
  swpp_tag_t           tag2;
  logic [SW-1:0]       range2;
  logic [SW-1:0]       best_q, best_new;
  logic                out_valid_q;
  swpp_out_t           out_word_q, out_word_d;
  logic [SW+RangeFieldW-1:0] range_ext, best_ext;

  // pipeline moves unless a finished word is held by the receiver
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign accept      = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= CfgW'(1);
    end else if (cfg_valid_i) begin
      len_cfg_q <= cfg_data_i;
    end
  end

  // clamp the length into 1 .. MAX_WINDOW
  always_comb begin
    logic [CmpW-1:0] len_ext;
    len_ext = CmpW'(len_cfg_q);
    if (len_cfg_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_ext > CmpW'(MAX_WINDOW)) begin
      eff_len = LenW'(MAX_WINDOW);
    end else begin
      eff_len = len_ext[LenW-1:0];
    end
  end

  // cell that covers exactly the samples held after this word
  assign sel_wide = SelW'(held) - SelW'(1);
  assign sel      = sel_wide[IW-1:0];

  // sample narrowed or widened to the working width
  assign sample_wide = {{SW{1'b0}}, in_word_i.sample};
  assign sample      = sample_wide[SW-1:0];

  // samples held after this word, saturating at the window length
  assign held_inc = restart_q ? (LenW + 1)'(1) : ({1'b0, fill_q} + (LenW + 1)'(1));
  assign held     = (held_inc > {1'b0, eff_len}) ? eff_len : held_inc[LenW-1:0];
  assign fill_d   = in_word_i.last ? '0 : held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      restart_q <= 1'b1;
      v0_q      <= 1'b0;
    end else if (en) begin
      v0_q <= accept;
      if (accept) begin
        fill_q    <= fill_d;
        restart_q <= in_word_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag0_q.full <= (held == eff_len);
      tag0_q.last <= in_word_i.last;
      sel0_q      <= sel;
    end
  end

  // row of cells, cell k covers the newest k+1 samples of the sequence
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic [SW-1:0] prev_min, prev_max;
    if (k == 0) begin : g_head
      assign prev_min = sample;
      assign prev_max = sample;
    end else begin : g_body
      assign prev_min = cell_min[k-1];
      assign prev_max = cell_max[k-1];
    end
    swpp_cell #(
      .SW (SW)
    ) u_cell (
      .clk_i      (clk_i),
      .load_i     (accept),
      .restart_i  (restart_q),
      .sample_i   (sample),
      .prev_min_i (prev_min),
      .prev_max_i (prev_max),
      .min_o      (cell_min[k]),
      .max_o      (cell_max[k])
    );
  end

  // read the cell at the held count and take its spread
  swpp_range #(
    .SW    (SW),
    .DEPTH (MAX_WINDOW),
    .IW    (IW)
  ) u_range (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v0_q),
    .tag_i      (tag0_q),
    .cell_min_i (cell_min),
    .cell_max_i (cell_max),
    .sel_i      (sel0_q),
    .valid_o    (v2),
    .tag_o      (tag2),
    .range_o    (range2)
  );

  // best spread over full windows of the sequence
  assign best_new  = (tag2.full && (range2 > best_q)) ? range2 : best_q;
  assign range_ext = {{RangeFieldW{1'b0}}, range2};
  assign best_ext  = {{RangeFieldW{1'b0}}, best_new};

  always_comb begin
    out_word_d.window_range = range_ext[RangeFieldW-1:0];
    out_word_d.window_full  = tag2.full;
    out_word_d.best_range   = best_ext[RangeFieldW-1:0];
    out_word_d.is_final     = tag2.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2;
      if (v2) begin
        best_q <= tag2.last ? '0 : best_new;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (en && v2) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
